FILE: sv/jass_pkg.sv
package jass_pkg;

    localparam logic [7:0]  SOI_FIRST_BYTE  = 8'hFF;
    localparam logic [7:0]  SOI_SECOND_BYTE = 8'hD8;

    localparam logic [15:0] SKIP_LOW_RESET  = 16'hFFE0;
    localparam logic [15:0] SKIP_HIGH_RESET = 16'hFFF0;
    localparam logic [15:0] SCAN_RESET      = 16'hFFDA;

    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SKIP_LOW  = 2'd0,
        CFG_SKIP_HIGH = 2'd1,
        CFG_SCAN      = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_JPEG  = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } end_status_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       file_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       out_last;
        logic [1:0] end_status;
    } out_item_t;

    typedef struct packed {
        logic [15:0] skip_low_marker;
        logic [15:0] skip_high_marker;
        logic [15:0] scan_start_marker;
    } cfg_t;

    // Group of up to two results written into the output queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } push_t;

endpackage

FILE: sv/jass_ifs.sv
interface jass_in_if;
    logic               valid;
    logic               ready;
    jass_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jass_out_if;
    logic                valid;
    logic                ready;
    jass_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jass_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [jass_pkg::CFG_INDEX_W-1:0]   index;
    logic [15:0]                        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/jass_cfg_regs.sv
module jass_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    jass_cfg_if.sink           cfg,
    output jass_pkg::cfg_t     regs
);
    import jass_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.skip_low_marker   <= SKIP_LOW_RESET;
            regs_reg.skip_high_marker  <= SKIP_HIGH_RESET;
            regs_reg.scan_start_marker <= SCAN_RESET;
        end
        else if (cfg.valid)
        begin
            // writes to unused indexes are dropped
            unique case (cfg.index)
                CFG_SKIP_LOW:  regs_reg.skip_low_marker   <= cfg.data;
                CFG_SKIP_HIGH: regs_reg.skip_high_marker  <= cfg.data;
                CFG_SCAN:      regs_reg.scan_start_marker <= cfg.data;
                default:       ;
            endcase
        end
    end

endmodule

FILE: sv/jass_parser.sv
module jass_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  jass_pkg::cfg_t     regs,
    input  logic               accept,
    input  jass_pkg::in_item_t item,
    output jass_pkg::push_t    push
);
    import jass_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR0,
        PH_HDR1,
        PH_REJECT,
        PH_ID_HI,
        PH_ID_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_COPY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  len_high_reg, len_high_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        dropping_reg, dropping_next;
    logic        scan_reg, scan_next;
    logic        hdr_ok_reg, hdr_ok_next;

    logic [7:0]  b;
    logic [15:0] seg_id;
    logic [15:0] seg_len;
    logic [15:0] rem_dec;
    logic        drop_id;
    out_item_t   r0, r1;
    logic [1:0]  n;
    end_status_t status;

    assign b       = item.file_byte;
    assign seg_id  = {held_reg, b};
    assign seg_len = {len_high_reg, b};
    assign rem_dec = remaining_reg - 16'd1;
    assign drop_id = (seg_id >= regs.skip_low_marker) && (seg_id <= regs.skip_high_marker);

    always_comb
    begin
        phase_next     = phase_reg;
        held_next      = held_reg;
        len_high_next  = len_high_reg;
        remaining_next = remaining_reg;
        dropping_next  = dropping_reg;
        scan_next      = scan_reg;
        hdr_ok_next    = hdr_ok_reg;
        r0             = '0;
        r1             = '0;
        n              = 2'd0;
        status         = STATUS_OK;

        unique case (phase_reg)
            PH_HDR0:
            begin
                hdr_ok_next = (b == SOI_FIRST_BYTE);
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                if (hdr_ok_reg && (b == SOI_SECOND_BYTE))
                begin
                    r0         = '{out_byte: SOI_FIRST_BYTE, byte_present: 1'b1, default: '0};
                    r1         = '{out_byte: SOI_SECOND_BYTE, byte_present: 1'b1, default: '0};
                    n          = 2'd2;
                    phase_next = PH_ID_HI;
                end
                else
                begin
                    phase_next = PH_REJECT;
                end
            end
            PH_REJECT:
            begin
            end
            PH_ID_HI:
            begin
                held_next  = b;
                phase_next = PH_ID_LO;
                // file cut inside an id: flush the first id byte
                if (item.file_last)
                begin
                    r0 = '{out_byte: b, byte_present: 1'b1, default: '0};
                    n  = 2'd1;
                end
            end
            PH_ID_LO:
            begin
                dropping_next = drop_id;
                if (seg_id == regs.scan_start_marker)
                begin
                    scan_next = 1'b1;
                end
                if (!drop_id)
                begin
                    r0 = '{out_byte: held_reg, byte_present: 1'b1, default: '0};
                    r1 = '{out_byte: b, byte_present: 1'b1, default: '0};
                    n  = 2'd2;
                end
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_high_next = b;
                if (!dropping_reg)
                begin
                    r0 = '{out_byte: b, byte_present: 1'b1, default: '0};
                    n  = 2'd1;
                end
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                if (!dropping_reg)
                begin
                    r0 = '{out_byte: b, byte_present: 1'b1, default: '0};
                    n  = 2'd1;
                end
                // length counts its own two bytes; below 2 means no payload
                remaining_next = (seg_len < 16'd2) ? 16'd0 : (seg_len - 16'd2);
                if (remaining_next == 16'd0)
                begin
                    phase_next = scan_reg ? PH_COPY : PH_ID_HI;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (!dropping_reg)
                begin
                    r0 = '{out_byte: b, byte_present: 1'b1, default: '0};
                    n  = 2'd1;
                end
                remaining_next = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    phase_next = scan_reg ? PH_COPY : PH_ID_HI;
                end
            end
            PH_COPY:
            begin
                r0 = '{out_byte: b, byte_present: 1'b1, default: '0};
                n  = 2'd1;
            end
            default:
            begin
                r0 = '{out_byte: b, byte_present: 1'b1, default: '0};
                n  = 2'd1;
            end
        endcase

        if (item.file_last)
        begin
            if ((phase_next == PH_REJECT) || (phase_next == PH_HDR1))
            begin
                status = STATUS_NOT_JPEG;
            end
            else
            begin
                status = scan_next ? STATUS_OK : STATUS_TRUNCATED;
            end

            unique case (n)
                2'd2:
                begin
                    r1.out_last   = 1'b1;
                    r1.end_status = status;
                end
                2'd1:
                begin
                    r0.out_last   = 1'b1;
                    r0.end_status = status;
                end
                default:
                begin
                    r0 = '{out_last: 1'b1, end_status: status, default: '0};
                    n  = 2'd1;
                end
            endcase

            phase_next     = PH_HDR0;
            held_next      = '0;
            len_high_next  = '0;
            remaining_next = '0;
            dropping_next  = 1'b0;
            scan_next      = 1'b0;
            hdr_ok_next    = 1'b0;
        end
    end

    assign push.count  = accept ? n : 2'd0;
    assign push.first  = r0;
    assign push.second = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            held_reg      <= '0;
            len_high_reg  <= '0;
            remaining_reg <= '0;
            dropping_reg  <= 1'b0;
            scan_reg      <= 1'b0;
            hdr_ok_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            len_high_reg  <= len_high_next;
            remaining_reg <= remaining_next;
            dropping_reg  <= dropping_next;
            scan_reg      <= scan_next;
            hdr_ok_reg    <= hdr_ok_next;
        end
    end

endmodule

FILE: sv/jass_out_queue.sv
module jass_out_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  jass_pkg::push_t push,
    output logic            space,
    jass_out_if.source      out
);
    import jass_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    out_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_plus1;

    // room for a full pair of results
    assign space        = (count_reg <= (PTR_W + 1)'(DEPTH - 2));
    assign out.valid    = (count_reg != '0);
    assign out.data     = mem_reg[rd_ptr_reg];
    assign pop          = out.valid && out.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/jpeg_app_segment_stripper_top.sv
// channel   dir   transfer when        payload
// in_ch     in    valid && ready       file_byte[7:0], file_last
// out_ch    out   valid && ready       out_byte[7:0], byte_present, out_last, end_status[1:0]
// cfg       in    valid && ready       index[1:0], data[15:0]
//
// One input byte per cycle while the queue has room for two results; each byte gives 0 to 2 results.
// Results sit in a 4-entry queue; in_ch.ready drops while fewer than two slots are free,
// so a stalled out_ch holds the input back after at most four queued results.
// Asynchronous active-low reset returns the parser to the first header byte.
// Results reach out_ch from the queue registers, never combinationally from the input.
module jpeg_app_segment_stripper_top (
    input  logic       clk,
    input  logic       rst_n,
    jass_in_if.sink    in_ch,
    jass_out_if.source out_ch,
    jass_cfg_if.sink   cfg
);
    import jass_pkg::*;

    cfg_t  regs;
    push_t push;
    logic  space;
    logic  accept;

    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    jass_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    jass_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .regs   (regs),
        .accept (accept),
        .item   (in_ch.data),
        .push   (push)
    );

    jass_out_queue u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (space),
        .out   (out_ch)
    );

endmodule
